FILE: hdl/gda_pkg.sv
`default_nettype none

package gda_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 20;
    localparam int DIST_W   = 23;
    localparam int WDAY_W   = 3;
    localparam int MODE_W   = 2;
    localparam int ORDER_W  = 2;
    localparam int STATUS_W = 2;

    // Months named where the logic turns on them
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // A Gregorian era: 400 years of 146097 days
    localparam logic [YEAR_W-1:0]  ERA_YEARS = 14'd400;
    localparam logic [COUNT_W-1:0] ERA_DAYS  = 20'd146097;
    localparam logic [DIST_W-1:0]  ERA_DAYS_D = 23'd146097;

    // Distance saturation limits
    localparam logic [DIST_W-1:0] DIST_POS_MAX = 23'h3FFFFF;
    localparam logic [DIST_W-1:0] DIST_NEG_MAG = 23'h400000;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2,
        MODE_DIFF = 2'd3
    } t_mode;

    typedef enum logic [ORDER_W-1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_WD1,
        S_WD2,
        S_WD3,
        S_OUT
    } t_state;

    // Quotient by 25 of a year value, by reciprocal multiply (exact below 2^14)
    function automatic logic [9:0] f_div25(input logic [YEAR_W-1:0] v);
        logic [26:0] p;
        p = {13'b0, v} * 27'd5243;
        return p[26:17];
    endfunction

    // Month length in a common year; zero for codes that are no month
    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gda_if.sv
`default_nettype none

// Command beat: mode and operands
interface gda_in_if;
    logic                              valid;
    logic                              ready;
    logic [gda_pkg::MODE_W-1:0]        mode;
    logic [gda_pkg::YEAR_W-1:0]        in_year;
    logic [gda_pkg::MONTH_W-1:0]       in_month;
    logic [gda_pkg::DAY_W-1:0]         in_day;
    logic [gda_pkg::COUNT_W-1:0]       day_count;

    modport source (output valid, mode, in_year, in_month, in_day, day_count,
                    input ready);
    modport sink   (input valid, mode, in_year, in_month, in_day, day_count,
                    output ready);
endinterface

// Result beat: stored date, weekday, distance, order and status
interface gda_out_if;
    logic                              valid;
    logic                              ready;
    logic [gda_pkg::YEAR_W-1:0]        out_year;
    logic [gda_pkg::MONTH_W-1:0]       out_month;
    logic [gda_pkg::DAY_W-1:0]         out_day;
    logic [gda_pkg::WDAY_W-1:0]        weekday;
    logic signed [gda_pkg::DIST_W-1:0] day_distance;
    logic [gda_pkg::ORDER_W-1:0]       order;
    logic [gda_pkg::STATUS_W-1:0]      status;

    modport source (output valid, out_year, out_month, out_day, weekday,
                    day_distance, order, status, input ready);
    modport sink   (input valid, out_year, out_month, out_day, weekday,
                    day_distance, order, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/gda_month_len.sv
`default_nettype none

module gda_month_len (
    input  wire logic [gda_pkg::YEAR_W-1:0]  i_year,
    input  wire logic [gda_pkg::MONTH_W-1:0] i_month,
    output logic      [gda_pkg::DAY_W-1:0]   o_days
);

    logic [9:0]                  q25;
    logic [gda_pkg::YEAR_W-1:0]  back25;
    logic                        leap;

    // Leap year: divisible by 4, and not by 100 unless by 400
    assign q25    = gda_pkg::f_div25(i_year);
    assign back25 = gda_pkg::YEAR_W'({4'b0, q25} * 14'd25);
    assign leap   = (i_year[1:0] == 2'b00) &&
                    ((back25 != i_year) || (i_year[3:0] == 4'b0000));

    // Add the leap day to February
    assign o_days = gda_pkg::f_month_days(i_month) +
                    gda_pkg::DAY_W'((i_month == gda_pkg::MONTH_FEB) && leap);

endmodule

`default_nettype wire

FILE: hdl/gregorian_date_arithmetic_unit.sv
`default_nettype none

// Channel   Dir  Beat contents
// i_item    in   mode, in_year, in_month, in_day, day_count
// o_result  out  out_year, out_month, out_day, weekday, day_distance, order, status
//
// One command at a time: accept, the check state, the calendar walk, the weekday
// states WD1, WD2 and WD3, then the result register. The walk steps one month per
// cycle through the shared month-length unit, with a 400-year jump per cycle while
// the span allows; load skips the walk. i_item.ready is high only while idle. A held
// result stalls the unit until taken. Reset (synchronous, active low) sets 1900-01-01.

module gregorian_date_arithmetic_unit #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gda_in_if.sink     i_item,
    gda_out_if.source  o_result
);

    localparam int YW = gda_pkg::YEAR_W;
    localparam int MW = gda_pkg::MONTH_W;
    localparam int DW = gda_pkg::DAY_W;
    localparam int CW = gda_pkg::COUNT_W;
    localparam int SW = gda_pkg::DIST_W;

    localparam logic [YW-1:0] MAX_Y   = YW'(MAX_YEAR);
    localparam logic [YW:0]   MAX_Y_X = (YW+1)'(MAX_YEAR);

    // Term 3(m+1)/5 of the weekday sum, months 3 to 14
    function automatic logic [3:0] f_month_term(input logic [MW-1:0] m);
        logic [3:0] t;
        unique case (m)
            4'd3:         t = 4'd2;
            4'd4, 4'd5:   t = 4'd3;
            4'd6, 4'd7:   t = 4'd4;
            4'd8:         t = 4'd5;
            4'd9, 4'd10:  t = 4'd6;
            4'd11, 4'd12: t = 4'd7;
            4'd13:        t = 4'd8;
            4'd14:        t = 4'd9;
            default:      t = 4'd0;
        endcase
        return t;
    endfunction

    gda_pkg::t_state  r_state, n_state;
    gda_pkg::t_mode   r_mode, n_mode;
    gda_pkg::t_order  r_order, n_order;
    gda_pkg::t_status r_status, n_status;

    logic [YW-1:0] r_gy, n_gy, r_cur_y, n_cur_y, r_wy, n_wy, r_ty, n_ty;
    logic [MW-1:0] r_gm, n_gm, r_cur_m, n_cur_m, r_wm, n_wm, r_tm, n_tm;
    logic [DW-1:0] r_gd, n_gd, r_cur_d, n_cur_d, r_wd, n_wd, r_td, n_td;
    logic [CW-1:0] r_rem, n_rem;
    logic [SW-1:0] r_acc, n_acc, r_dist, n_dist;
    logic          r_neg, n_neg;
    logic [14:0]   r_wsum, n_wsum;
    logic [9:0]    r_q100, n_q100;

    logic          r_o_valid, n_o_valid;
    logic [YW-1:0] r_o_year, n_o_year;
    logic [MW-1:0] r_o_month, n_o_month;
    logic [DW-1:0] r_o_day, n_o_day;
    logic [2:0]    r_o_wday, n_o_wday;
    logic [SW-1:0] r_o_dist, n_o_dist;
    logic [1:0]    r_o_order, n_o_order;
    logic [1:0]    r_o_status, n_o_status;

    logic          accept;
    logic          check_to_walk;
    logic          walk_end;

    logic [YW-1:0] mu_year;
    logic [MW-1:0] mu_month;
    logic [DW-1:0] mu_days;

    logic          given_valid;
    logic          cur_lt, cur_eq;
    logic [DW-1:0] left;
    logic [YW:0]   wy_up;
    logic [SW-1:0] mag;

    logic          early;
    logic [YW-1:0] ya;
    logic [MW-1:0] ma;
    logic [29:0]   p7;
    logic [12:0]   q7;
    logic [14:0]   rem7;

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == gda_pkg::S_IDLE);

    // Feed the shared month-length unit: given date while checking,
    // previous month while walking backwards, else the working month
    always_comb begin
        mu_year  = r_wy;
        mu_month = r_wm;
        if (r_state == gda_pkg::S_CHECK) begin
            mu_year  = r_gy;
            mu_month = r_gm;
        end else if (r_mode == gda_pkg::MODE_SUB) begin
            mu_month = (r_wm == gda_pkg::MONTH_JAN) ? gda_pkg::MONTH_DEC : r_wm - 4'd1;
        end
    end

    gda_month_len u_month_len (
        .i_year  (mu_year),
        .i_month (mu_month),
        .o_days  (mu_days)
    );

    // Checks and compares on the captured operands
    assign given_valid = (r_gy != '0) && (r_gy <= MAX_Y) &&
                         (r_gm >= gda_pkg::MONTH_JAN) && (r_gm <= gda_pkg::MONTH_DEC) &&
                         (r_gd != '0) && (r_gd <= mu_days);
    assign cur_lt = {r_cur_y, r_cur_m, r_cur_d} < {r_gy, r_gm, r_gd};
    assign cur_eq = {r_cur_y, r_cur_m, r_cur_d} == {r_gy, r_gm, r_gd};

    assign left  = mu_days - r_wd;
    assign wy_up = {1'b0, r_wy} + {1'b0, gda_pkg::ERA_YEARS};
    assign mag   = r_acc + SW'(r_td - r_wd);

    // Weekday operands: January and February count in the previous year
    assign early = (r_cur_m <= gda_pkg::MONTH_FEB);
    assign ya    = early ? r_cur_y - 14'd1 : r_cur_y;
    assign ma    = early ? r_cur_m + 4'd12 : r_cur_m;
    assign p7    = {15'b0, r_wsum} * 30'd18725;
    assign q7    = p7[29:17];
    assign rem7  = r_wsum - 15'(q7 * 15'd7);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gda_pkg::S_IDLE:  if (accept) n_state = gda_pkg::S_CHECK;
            gda_pkg::S_CHECK: n_state = check_to_walk ? gda_pkg::S_WALK : gda_pkg::S_WD1;
            gda_pkg::S_WALK:  if (walk_end) n_state = gda_pkg::S_WD1;
            gda_pkg::S_WD1:   n_state = gda_pkg::S_WD2;
            gda_pkg::S_WD2:   n_state = gda_pkg::S_WD3;
            gda_pkg::S_WD3:   n_state = gda_pkg::S_OUT;
            gda_pkg::S_OUT:   if (o_result.ready) n_state = gda_pkg::S_IDLE;
            default:          n_state = gda_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_mode = r_mode;   n_order = r_order; n_status = r_status;
        n_gy = r_gy;       n_gm = r_gm;       n_gd = r_gd;
        n_cur_y = r_cur_y; n_cur_m = r_cur_m; n_cur_d = r_cur_d;
        n_wy = r_wy;       n_wm = r_wm;       n_wd = r_wd;
        n_ty = r_ty;       n_tm = r_tm;       n_td = r_td;
        n_rem = r_rem;     n_acc = r_acc;     n_dist = r_dist;
        n_neg = r_neg;     n_wsum = r_wsum;   n_q100 = r_q100;
        n_o_valid = r_o_valid;
        n_o_year = r_o_year;   n_o_month = r_o_month; n_o_day = r_o_day;
        n_o_wday = r_o_wday;   n_o_dist = r_o_dist;
        n_o_order = r_o_order; n_o_status = r_o_status;
        check_to_walk = 1'b0;
        walk_end      = 1'b0;

        unique case (r_state)
            // Capture the command beat
            gda_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode = gda_pkg::t_mode'(i_item.mode);
                    n_gy   = i_item.in_year;
                    n_gm   = i_item.in_month;
                    n_gd   = i_item.in_day;
                    n_rem  = i_item.day_count;
                end
            end

            // Validate, order and set up the walk
            gda_pkg::S_CHECK: begin
                n_status = gda_pkg::ST_OK;
                n_order  = gda_pkg::ORD_LESS;
                n_dist   = '0;
                n_acc    = '0;
                n_neg    = 1'b0;
                n_wy = r_cur_y; n_wm = r_cur_m; n_wd = r_cur_d;
                unique case (r_mode)
                    gda_pkg::MODE_LOAD: begin
                        if (given_valid) begin
                            n_cur_y = r_gy; n_cur_m = r_gm; n_cur_d = r_gd;
                        end else begin
                            n_status = gda_pkg::ST_BAD_DATE;
                        end
                    end
                    gda_pkg::MODE_ADD, gda_pkg::MODE_SUB: begin
                        check_to_walk = 1'b1;
                    end
                    gda_pkg::MODE_DIFF: begin
                        if (!given_valid) begin
                            n_status = gda_pkg::ST_BAD_DATE;
                        end else if (cur_eq) begin
                            n_order = gda_pkg::ORD_EQUAL;
                        end else if (cur_lt) begin
                            check_to_walk = 1'b1;
                            n_order = gda_pkg::ORD_LESS;
                            n_neg   = 1'b1;
                            n_ty = r_gy; n_tm = r_gm; n_td = r_gd;
                        end else begin
                            check_to_walk = 1'b1;
                            n_order = gda_pkg::ORD_GREATER;
                            n_wy = r_gy; n_wm = r_gm; n_wd = r_gd;
                            n_ty = r_cur_y; n_tm = r_cur_m; n_td = r_cur_d;
                        end
                    end
                    default: ;
                endcase
            end

            // One month, or one 400-year era, per cycle
            gda_pkg::S_WALK: begin
                unique case (r_mode)
                    gda_pkg::MODE_ADD: begin
                        if (r_rem >= gda_pkg::ERA_DAYS) begin
                            if (wy_up > MAX_Y_X) begin
                                walk_end = 1'b1;
                                n_status = gda_pkg::ST_RANGE;
                            end else begin
                                n_wy  = wy_up[YW-1:0];
                                n_rem = r_rem - gda_pkg::ERA_DAYS;
                            end
                        end else if (r_rem <= CW'(left)) begin
                            walk_end = 1'b1;
                            n_cur_y  = r_wy;
                            n_cur_m  = r_wm;
                            n_cur_d  = r_wd + r_rem[DW-1:0];
                        end else begin
                            n_rem = r_rem - CW'(left) - 20'd1;
                            n_wd  = 5'd1;
                            if (r_wm == gda_pkg::MONTH_DEC) begin
                                if (r_wy == MAX_Y) begin
                                    walk_end = 1'b1;
                                    n_status = gda_pkg::ST_RANGE;
                                end else begin
                                    n_wy = r_wy + 14'd1;
                                    n_wm = gda_pkg::MONTH_JAN;
                                end
                            end else begin
                                n_wm = r_wm + 4'd1;
                            end
                        end
                    end
                    gda_pkg::MODE_SUB: begin
                        if (r_rem >= gda_pkg::ERA_DAYS) begin
                            if (r_wy <= gda_pkg::ERA_YEARS) begin
                                walk_end = 1'b1;
                                n_status = gda_pkg::ST_RANGE;
                            end else begin
                                n_wy  = r_wy - gda_pkg::ERA_YEARS;
                                n_rem = r_rem - gda_pkg::ERA_DAYS;
                            end
                        end else if (r_rem < CW'(r_wd)) begin
                            walk_end = 1'b1;
                            n_cur_y  = r_wy;
                            n_cur_m  = r_wm;
                            n_cur_d  = r_wd - r_rem[DW-1:0];
                        end else begin
                            // Step back to the last day of the previous month
                            n_rem = r_rem - CW'(r_wd);
                            n_wd  = mu_days;
                            if (r_wm == gda_pkg::MONTH_JAN) begin
                                if (r_wy == 14'd1) begin
                                    walk_end = 1'b1;
                                    n_status = gda_pkg::ST_RANGE;
                                end else begin
                                    n_wy = r_wy - 14'd1;
                                    n_wm = gda_pkg::MONTH_DEC;
                                end
                            end else begin
                                n_wm = r_wm - 4'd1;
                            end
                        end
                    end
                    gda_pkg::MODE_DIFF: begin
                        if ((r_ty - r_wy) > gda_pkg::ERA_YEARS) begin
                            n_wy  = r_wy + gda_pkg::ERA_YEARS;
                            n_acc = r_acc + gda_pkg::ERA_DAYS_D;
                        end else if ((r_wy == r_ty) && (r_wm == r_tm)) begin
                            walk_end = 1'b1;
                            // Saturate the signed distance to the field
                            if (r_neg) begin
                                n_dist = (mag > gda_pkg::DIST_NEG_MAG) ?
                                         gda_pkg::DIST_NEG_MAG : SW'(~mag + 23'd1);
                            end else begin
                                n_dist = (mag > gda_pkg::DIST_POS_MAX) ?
                                         gda_pkg::DIST_POS_MAX : mag;
                            end
                        end else begin
                            n_acc = r_acc + SW'(left) + 23'd1;
                            n_wd  = 5'd1;
                            if (r_wm == gda_pkg::MONTH_DEC) begin
                                n_wy = r_wy + 14'd1;
                                n_wm = gda_pkg::MONTH_JAN;
                            end else begin
                                n_wm = r_wm + 4'd1;
                            end
                        end
                    end
                    default: walk_end = 1'b1;
                endcase
            end

            // Weekday sum without the century terms
            gda_pkg::S_WD1: begin
                n_q100 = gda_pkg::f_div25({2'b00, ya[YW-1:2]});
                n_wsum = 15'(r_cur_d) + 15'({ma, 1'b0}) + 15'(f_month_term(ma)) +
                         15'(ya) + 15'(ya[YW-1:2]);
            end

            // Take off y/100, add back y/400
            gda_pkg::S_WD2: begin
                n_wsum = r_wsum - 15'(r_q100) + 15'(r_q100[9:2]);
            end

            // Reduce mod 7 and load the result register
            gda_pkg::S_WD3: begin
                n_o_valid  = 1'b1;
                n_o_year   = r_cur_y;
                n_o_month  = r_cur_m;
                n_o_day    = r_cur_d;
                n_o_wday   = rem7[2:0] + 3'd1;
                n_o_dist   = r_dist;
                n_o_order  = r_order;
                n_o_status = r_status;
            end

            // Hold the beat until taken
            gda_pkg::S_OUT: begin
                if (o_result.ready) n_o_valid = 1'b0;
            end

            default: ;
        endcase
    end

    // Control state and stored date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gda_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_cur_y   <= 14'd1900;
            r_cur_m   <= gda_pkg::MONTH_JAN;
            r_cur_d   <= 5'd1;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cur_y   <= n_cur_y;
            r_cur_m   <= n_cur_m;
            r_cur_d   <= n_cur_d;
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;   r_order <= n_order; r_status <= n_status;
        r_gy <= n_gy;       r_gm <= n_gm;       r_gd <= n_gd;
        r_wy <= n_wy;       r_wm <= n_wm;       r_wd <= n_wd;
        r_ty <= n_ty;       r_tm <= n_tm;       r_td <= n_td;
        r_rem <= n_rem;     r_acc <= n_acc;     r_dist <= n_dist;
        r_neg <= n_neg;     r_wsum <= n_wsum;   r_q100 <= n_q100;
        r_o_year <= n_o_year;   r_o_month <= n_o_month; r_o_day <= n_o_day;
        r_o_wday <= n_o_wday;   r_o_dist <= n_o_dist;
        r_o_order <= n_o_order; r_o_status <= n_o_status;
    end

    assign o_result.valid        = r_o_valid;
    assign o_result.out_year     = r_o_year;
    assign o_result.out_month    = r_o_month;
    assign o_result.out_day      = r_o_day;
    assign o_result.weekday      = r_o_wday;
    assign o_result.day_distance = $signed(r_o_dist);
    assign o_result.order        = r_o_order;
    assign o_result.status       = r_o_status;

endmodule

`default_nettype wire
